@@ rtl/hnm_pkg.sv @@
// Shared constants, register indexes and arithmetic helpers for the normal map core.
package hnm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_SCALE = 2'd2;

  localparam logic [10:0] IMAGE_WIDTH_RST    = 11'd2;
  localparam logic [15:0] IMAGE_HEIGHT_RST   = 16'd2;
  localparam logic [15:0] VERTICAL_SCALE_RST = 16'd256;

  // root / divide unit step counts
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 17;

  localparam logic [17:0] ONE_Q16 = 18'h10000;
  localparam logic [17:0] TWO_Q16 = 18'h20000;
  localparam logic [63:0] GRAD_MAX = 64'h0000_0000_7FFF_FFFF;

  // shift by span (two inside, one at an edge) and saturate to Q16.16 magnitude
  function automatic logic [30:0] grad_sat(input logic [63:0] p, input logic inner);
    logic [63:0] s;
    begin
      s = inner ? (p >> 2) : (p >> 1);
      grad_sat = (s > GRAD_MAX) ? GRAD_MAX[30:0] : s[30:0];
    end
  endfunction

  // offset a signed component by one and clamp to [0, 2.0]
  function automatic logic [17:0] comp_u(input logic neg, input logic [31:0] v);
    logic [32:0] s;
    begin
      s = {1'b0, v} + {15'd0, ONE_Q16};
      if (neg) begin
        comp_u = (s > {15'd0, TWO_Q16}) ? TWO_Q16 : s[17:0];
      end else if (v > {14'd0, ONE_Q16}) begin
        comp_u = 18'd0;
      end else begin
        comp_u = ONE_Q16 - v[17:0];
      end
    end
  endfunction

  // floor((u * 255 + 1.0) / 2^17)
  function automatic logic [7:0] enc_u(input logic [17:0] u);
    logic [25:0] t;
    begin
      t = {u, 8'd0} - {8'd0, u} + {8'd0, ONE_Q16};
      enc_u = t[24:17];
    end
  endfunction

endpackage

@@ rtl/hnm_in_if.sv @@
// Input channel: height sample and drain transactions.
interface hnm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] height_sample;

  modport source (output valid, output mode, output height_sample, input ready);
  modport sink   (input valid, input mode, input height_sample, output ready);
endinterface

@@ rtl/hnm_out_if.sv @@
// Result channel: encoded normal transactions.
interface hnm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, output red, output green, output blue, output frame_end,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input frame_end,
                  output ready);
endinterface

@@ rtl/hnm_line_buf.sv @@
// Two row stores with registered reads; older row is refilled from the previous row.
module hnm_line_buf #(
  parameter  int MAX_WIDTH = hnm_pkg::MAX_WIDTH_DEF,
  localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                 clk,
  input  logic [AW-1:0]        rd_addr_old,
  input  logic [AW-1:0]        rd_addr_prev,
  input  logic                 we,
  input  logic [AW-1:0]        wr_addr,
  input  logic [15:0]          wr_sample,
  output logic [15:0]          old_q,
  output logic [15:0]          prev_q
);
  logic [15:0] old_mem  [MAX_WIDTH];
  logic [15:0] prev_mem [MAX_WIDTH];
  logic [15:0] old_q_r;
  logic [15:0] prev_q_r;

  // older row takes the entry last read from the previous row
  always_ff @(posedge clk) begin
    if (we) begin
      old_mem[wr_addr]  <= prev_q_r;
      prev_mem[wr_addr] <= wr_sample;
    end
    old_q_r  <= old_mem[rd_addr_old];
    prev_q_r <= prev_mem[rd_addr_prev];
  end

  assign old_q  = old_q_r;
  assign prev_q = prev_q_r;
endmodule

@@ rtl/hnm_mul.sv @@
// Shared 32x32 multiplier with registered product.
module hnm_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= {32'd0, a} * {32'd0, b};
  end

  assign p = p_r;
endmodule

@@ rtl/hnm_root_div.sv @@
// Radix-2 integer square root followed by 2^32 / root, on one shared subtractor.
module hnm_root_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [16:0] quot
);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ROOT = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]  phase_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [16:0] quot_r;

  logic [33:0] op_a;
  logic [33:0] op_b;
  logic [34:0] diff;
  logic        ge;

  always_comb begin
    if (phase_r == PH_ROOT) begin
      op_a = {rem_r[31:0], rad_r[63:62]};
      op_b = {root_r, 2'b01};
    end else begin
      op_a = {rem_r[32:0], 1'b0};
      op_b = {2'b00, root_r};
    end
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = !diff[34];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_ROOT;
            cnt_r   <= '0;
            rad_r   <= radicand;
            rem_r   <= '0;
            root_r  <= '0;
          end
        end
        PH_ROOT: begin
          rad_r  <= {rad_r[61:0], 2'b00};
          root_r <= {root_r[30:0], ge};
          cnt_r  <= cnt_r + 5'd1;
          if (32'(cnt_r) == hnm_pkg::ROOT_STEPS - 1) begin
            // root is at least 2^16, so a start remainder of 2^15 keeps 17 quotient bits
            phase_r <= PH_DIV;
            cnt_r   <= '0;
            rem_r   <= 34'h8000;
            quot_r  <= '0;
          end else begin
            rem_r <= ge ? diff[33:0] : op_a;
          end
        end
        PH_DIV: begin
          rem_r  <= ge ? diff[33:0] : op_a;
          quot_r <= {quot_r[15:0], ge};
          cnt_r  <= cnt_r + 5'd1;
          if (32'(cnt_r) == hnm_pkg::DIV_STEPS - 1) begin
            phase_r <= PH_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (quot_r <= 17'h10000))
    else $error("reciprocal root above one");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIV) |-> (root_r >= 32'h10000))
    else $error("root below 2^16 entering divide");
endmodule

@@ rtl/heightfield_normal_map_core.sv @@
// Height field to normal map core: row buffering, sequencer and output register.
// Each pixel takes 49 steps of the shared root/divide subtractor (32 root bits, 17 quotient
//   bits) plus 8 passes through the shared multiplier; no new sample is accepted until it is done.
// Non-emitting samples pass only through the row-store read states RD0 to RD3; ignored drains stay idle.
// Reset (rst_n, synchronous, active low) clears counters, state and output valid and loads config defaults;
//   row stores keep undefined contents until streamed, and no clearing pass is run.
module heightfield_normal_map_core #(
  parameter int MAX_WIDTH = hnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hnm_in_if.sink                          in_ch,
  hnm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hnm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 2);   // column count reaches the width when draining
  localparam int PW = $clog2(MAX_WIDTH + 3);   // pending count reaches width + 1

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RD0  = 5'd1;
  localparam logic [4:0] ST_RD1  = 5'd2;
  localparam logic [4:0] ST_RD2  = 5'd3;
  localparam logic [4:0] ST_RD3  = 5'd4;
  localparam logic [4:0] ST_MX1  = 5'd5;
  localparam logic [4:0] ST_MX2  = 5'd6;
  localparam logic [4:0] ST_MZ1  = 5'd7;
  localparam logic [4:0] ST_MZ2  = 5'd8;
  localparam logic [4:0] ST_SQX  = 5'd9;
  localparam logic [4:0] ST_SQZ  = 5'd10;
  localparam logic [4:0] ST_SUM  = 5'd11;
  localparam logic [4:0] ST_ROOT = 5'd12;
  localparam logic [4:0] ST_NX   = 5'd13;
  localparam logic [4:0] ST_NZ   = 5'd14;
  localparam logic [4:0] ST_ENC  = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  // configuration
  logic [10:0] cfg_w_r;
  logic [15:0] cfg_h_r;
  logic [15:0] scale_r;

  // frame position
  logic [4:0]    st_r;
  logic [CW-1:0] c_r;
  logic [15:0]   r_r;
  logic [PW-1:0] pend_r;
  logic [CW-1:0] fw_r;
  logic [15:0]   fh_r;
  logic [15:0]   cd0_r;     // last sample evicted from the older row

  // per-transaction context
  logic          emit_r, fe_r, lv_r, rv_r, dv_r, uv_r, wen_r;
  logic [CW-1:0] px_r;
  logic [AW-1:0] wa_r;
  logic [15:0]   sample_r, down_r, left_r, up_r, center_r, right_r;
  logic [30:0]   gx_r, gz_r;
  logic [63:0]   sq_r;
  logic [31:0]   vx_r, vz_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] red_r, green_r, blue_r;
  logic       out_fe_r;

  // accept decode
  logic          accept, idle_fr, draining, ignore, emit, frame_end;
  logic [CW-1:0] fw_cfg, fw_eff, c1, px, c_nxt;
  logic [15:0]   fh_cfg, fh_eff, r_nxt;
  logic [PW-1:0] pend_inc, pend_nxt;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    if (cfg_w_r < 11'd2) begin
      fw_cfg = CW'(2);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      fw_cfg = CW'(MAX_WIDTH);
    end else begin
      fw_cfg = CW'(cfg_w_r);
    end
    fh_cfg = (cfg_h_r < 16'd2) ? 16'd2 : cfg_h_r;
  end

  always_comb begin
    idle_fr  = (c_r == '0) && (r_r == '0) && (pend_r == '0);
    // geometry is latched by the first sample of a frame
    fw_eff   = idle_fr ? fw_cfg : fw_r;
    fh_eff   = idle_fr ? fh_cfg : fh_r;
    draining = (r_r >= fh_eff);
    ignore   = in_ch.mode && !draining;
    emit     = draining || (r_r >= 16'd2) || ((r_r == 16'd1) && (c_r != '0));
    pend_inc = pend_r + PW'(!draining);
    pend_nxt = pend_inc - PW'(emit && (pend_inc != '0));
    frame_end = draining && (pend_nxt == '0);
    c1 = c_r + CW'(1);
    if (frame_end) begin
      c_nxt = '0;
      r_nxt = '0;
    end else if (!draining && (c1 >= fw_eff)) begin
      c_nxt = '0;
      r_nxt = r_r + 16'd1;
    end else begin
      c_nxt = c1;
      r_nxt = r_r;
    end
    // pixel one behind the write column (last of the row above when column is zero)
    px = (c_r == '0) ? (fw_eff - CW'(1)) : (c_r - CW'(1));
  end

  // row stores
  logic [CW-1:0] pxm1, pxp1;
  logic [AW-1:0] rd_old, rd_prev;
  logic [15:0]   old_q, prev_q;
  logic          lb_we;

  assign pxm1 = px_r - CW'(1);
  assign pxp1 = px_r + CW'(1);

  always_comb begin
    case (st_r)
      ST_RD0: begin
        rd_old  = pxm1[AW-1:0];
        rd_prev = px_r[AW-1:0];
      end
      ST_RD1: begin
        rd_old  = px_r[AW-1:0];
        rd_prev = pxp1[AW-1:0];
      end
      default: begin
        rd_old  = wa_r;
        rd_prev = wa_r;
      end
    endcase
  end

  assign lb_we = (st_r == ST_RD3) && wen_r;

  hnm_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk          (clk),
    .rd_addr_old  (rd_old),
    .rd_addr_prev (rd_prev),
    .we           (lb_we),
    .wr_addr      (wa_r),
    .wr_sample    (sample_r),
    .old_q        (old_q),
    .prev_q       (prev_q)
  );

  // neighbour selection, clamped at the borders
  logic [15:0] nl, nr, nd, nu;
  logic [16:0] dx, dz, ax, az;

  assign nl = lv_r ? left_r  : center_r;
  assign nr = rv_r ? right_r : center_r;
  assign nd = dv_r ? down_r  : center_r;
  assign nu = uv_r ? up_r    : center_r;
  assign dx = {nr[15], nr} - {nl[15], nl};
  assign dz = {nu[15], nu} - {nd[15], nd};
  assign ax = dx[16] ? (~dx + 17'd1) : dx;
  assign az = dz[16] ? (~dz + 17'd1) : dz;

  // shared multiplier
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [CW-1:0] fwm1;
  logic [16:0]   recip;
  logic          root_done;

  assign fwm1 = fw_r - CW'(1);

  always_comb begin
    case (st_r)
      ST_MX1: begin
        mul_a = {16'd0, ax[15:0]};
        mul_b = {16'd0, scale_r};
      end
      ST_MX2: begin
        mul_a = mul_p[31:0];
        mul_b = 32'(fwm1);
      end
      ST_MZ1: begin
        mul_a = {16'd0, az[15:0]};
        mul_b = {16'd0, scale_r};
      end
      ST_MZ2: begin
        mul_a = mul_p[31:0];
        mul_b = {16'd0, fh_r - 16'd1};
      end
      ST_SQX: begin
        mul_a = {1'b0, gx_r};
        mul_b = {1'b0, gx_r};
      end
      ST_SQZ: begin
        mul_a = {1'b0, gz_r};
        mul_b = {1'b0, gz_r};
      end
      ST_NX: begin
        mul_a = {1'b0, gx_r};
        mul_b = {15'd0, recip};
      end
      ST_NZ: begin
        mul_a = {1'b0, gz_r};
        mul_b = {15'd0, recip};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hnm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // S = gx^2 + gz^2 + 1.0 in Q32.32
  logic [63:0] sum_s;
  assign sum_s = sq_r + mul_p + 64'h1_0000_0000;

  hnm_root_div u_root_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (st_r == ST_SUM),
    .radicand (sum_s),
    .done     (root_done),
    .quot     (recip)
  );

  // encode for the output register
  logic       out_load;
  logic [7:0] enc_r, enc_g, enc_b;

  assign out_load = (st_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign enc_r = hnm_pkg::enc_u(hnm_pkg::comp_u(dx[16], vx_r));
  assign enc_g = hnm_pkg::enc_u({1'b0, recip} + hnm_pkg::ONE_Q16);
  assign enc_b = hnm_pkg::enc_u(hnm_pkg::comp_u(dz[16], vz_r));

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= hnm_pkg::IMAGE_WIDTH_RST;
      cfg_h_r     <= hnm_pkg::IMAGE_HEIGHT_RST;
      scale_r     <= hnm_pkg::VERTICAL_SCALE_RST;
      st_r        <= ST_IDLE;
      c_r         <= '0;
      r_r         <= '0;
      pend_r      <= '0;
      fw_r        <= CW'(2);
      fh_r        <= 16'd2;
      cd0_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          hnm_pkg::CFG_IMAGE_WIDTH:    cfg_w_r <= cfg_wdata[10:0];
          hnm_pkg::CFG_IMAGE_HEIGHT:   cfg_h_r <= cfg_wdata;
          hnm_pkg::CFG_VERTICAL_SCALE: scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (st_r)
        ST_IDLE: begin
          if (accept && !ignore) begin
            fw_r     <= fw_eff;
            fh_r     <= fh_eff;
            c_r      <= c_nxt;
            r_r      <= r_nxt;
            pend_r   <= pend_nxt;
            emit_r   <= emit;
            fe_r     <= frame_end;
            px_r     <= px;
            lv_r     <= (px != '0);
            rv_r     <= (px != fw_eff - CW'(1));
            dv_r     <= (c_r == '0) ? (r_r > 16'd2) : (r_r > 16'd1);
            uv_r     <= (c_r == '0) ? (r_r <= fh_eff) : (r_r < fh_eff);
            wen_r    <= (c_r < fw_eff);
            wa_r     <= c_r[AW-1:0];
            sample_r <= draining ? 16'd0 : in_ch.height_sample;
            down_r   <= cd0_r;
            st_r     <= ST_RD0;
          end
        end
        ST_RD0: st_r <= ST_RD1;
        ST_RD1: begin
          left_r <= old_q;
          up_r   <= prev_q;
          st_r   <= ST_RD2;
        end
        ST_RD2: begin
          center_r <= old_q;
          right_r  <= prev_q;
          st_r     <= ST_RD3;
        end
        ST_RD3: begin
          // old_q is the evicted older-row entry at the write column
          if (wen_r) begin
            cd0_r <= old_q;
          end
          st_r <= emit_r ? ST_MX1 : ST_IDLE;
        end
        ST_MX1: st_r <= ST_MX2;
        ST_MX2: st_r <= ST_MZ1;
        ST_MZ1: begin
          gx_r <= hnm_pkg::grad_sat(mul_p, lv_r && rv_r);
          st_r <= ST_MZ2;
        end
        ST_MZ2: st_r <= ST_SQX;
        ST_SQX: begin
          gz_r <= hnm_pkg::grad_sat(mul_p, dv_r && uv_r);
          st_r <= ST_SQZ;
        end
        ST_SQZ: begin
          sq_r <= mul_p;
          st_r <= ST_SUM;
        end
        ST_SUM: st_r <= ST_ROOT;
        ST_ROOT: begin
          if (root_done) begin
            st_r <= ST_NX;
          end
        end
        ST_NX: st_r <= ST_NZ;
        ST_NZ: begin
          vx_r <= mul_p[47:16];
          st_r <= ST_ENC;
        end
        ST_ENC: begin
          vz_r <= mul_p[47:16];
          st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_r    <= enc_r;
      green_r  <= enc_g;
      blue_r   <= enc_b;
      out_fe_r <= fe_r;
    end
  end

  assign in_ch.ready      = (st_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.red       = red_r;
  assign out_ch.green     = green_r;
  assign out_ch.blue      = blue_r;
  assign out_ch.frame_end = out_fe_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(pend_r) <= MAX_WIDTH + 1))
    else $error("pending count above one row plus one");

  a_frame_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_OUT) && fe_r) |-> ((c_r == '0) && (r_r == '0) && (pend_r == '0)))
    else $error("frame end without counters back at idle");

  a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (st_r == ST_ROOT))
    else $error("root unit finished outside its wait state");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (c_r <= fw_r))
    else $error("column count beyond frame width");
endmodule
